// ----- rtl/u2u8_pkg.sv -----
// shared types, constants and byte encoding helpers for the utf-16/32 to utf-8 transcoder
package u2u8_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [31:0] MAX_CP       = 32'h0010_FFFF;
  localparam logic [20:0] REPLACE_CP   = 21'h00_FFFD;
  localparam logic [15:0] SURR_FIRST   = 16'hD800;
  localparam logic [15:0] SURR_HI_LAST = 16'hDBFF;
  localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
  localparam logic [15:0] SURR_LAST    = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h01_0000;
  localparam logic [2:0]  REPLACE_LEN  = 3'd3;

  typedef struct packed {
    logic [31:0] code_unit;
    logic        final_unit;
  } unit_word_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_end;
  } byte_word_t;

  // one queued job: optional replacement char first, then optional code point
  typedef struct packed {
    logic        lead_fffd;
    logic        has_cp;
    logic [20:0] cp;
  } u2u8_job_t;

  // number of utf-8 bytes for a code point that is already in range
  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] len;
    begin
      if (cp <= 21'h00_007F)      len = 3'd1;
      else if (cp <= 21'h00_07FF) len = 3'd2;
      else if (cp <= 21'h00_FFFF) len = 3'd3;
      else                        len = 3'd4;
      return len;
    end
  endfunction

  // byte k of the len-byte encoding of cp
  function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp, input logic [2:0] len,
                                              input logic [1:0] k);
    logic [7:0] b;
    begin
      b = 8'h00;
      case (len)
        3'd1: b = {1'b0, cp[6:0]};
        3'd2: begin
          case (k)
            2'd0:    b = 8'hC0 | {3'b000, cp[10:6]};
            default: b = 8'h80 | {2'b00, cp[5:0]};
          endcase
        end
        3'd3: begin
          case (k)
            2'd0:    b = 8'hE0 | {4'h0, cp[15:12]};
            2'd1:    b = 8'h80 | {2'b00, cp[11:6]};
            default: b = 8'h80 | {2'b00, cp[5:0]};
          endcase
        end
        default: begin
          case (k)
            2'd0:    b = 8'hF0 | {5'b00000, cp[20:18]};
            2'd1:    b = 8'h80 | {2'b00, cp[17:12]};
            2'd2:    b = 8'h80 | {2'b00, cp[11:6]};
            default: b = 8'h80 | {2'b00, cp[5:0]};
          endcase
        end
      endcase
      return b;
    end
  endfunction

endpackage

// ----- rtl/u2u8_front.sv -----
// front end: accepts code units, pairs surrogates, queues code point jobs
module u2u8_front
  import u2u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       unit_valid,
  output logic       unit_stall,
  input  unit_word_t unit_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  output logic       push,
  output u2u8_job_t  push_job,
  input  logic       queue_full
);

  logic       wide_units;
  logic       high_is_held;
  logic [9:0] held_high_bits;
  logic       high_is_held_next;
  logic [9:0] held_high_bits_next;
  logic       accept;
  logic [15:0] u;
  logic       is_low;
  logic       is_high;
  logic       cp_bad;

  assign cfg_ready  = 1'b1;
  assign unit_stall = queue_full;
  assign accept     = unit_valid && !unit_stall;

  assign u       = unit_word.code_unit[15:0];
  assign is_low  = u inside {[SURR_LO_FIRST:SURR_LAST]};
  assign is_high = u inside {[SURR_FIRST:SURR_HI_LAST]};
  assign cp_bad  = (unit_word.code_unit > MAX_CP) ||
                   (unit_word.code_unit inside
                      {[{16'h0000, SURR_FIRST}:{16'h0000, SURR_LAST}]});

  always_comb begin
    push_job            = '0;
    high_is_held_next   = high_is_held;
    held_high_bits_next = held_high_bits;
    if (wide_units) begin
      push_job.has_cp = 1'b1;
      push_job.cp     = cp_bad ? REPLACE_CP : unit_word.code_unit[20:0];
    end else if (high_is_held && is_low) begin
      push_job.has_cp     = 1'b1;
      push_job.cp         = SUPP_BASE + {1'b0, held_high_bits, u[9:0]};
      high_is_held_next   = 1'b0;
      held_high_bits_next = '0;
    end else begin
      push_job.lead_fffd  = high_is_held;
      high_is_held_next   = 1'b0;
      held_high_bits_next = '0;
      if (is_high && !unit_word.final_unit) begin
        high_is_held_next   = 1'b1;
        held_high_bits_next = u[9:0];
      end else begin
        push_job.has_cp = 1'b1;
        push_job.cp     = (is_low || is_high) ? REPLACE_CP : {5'b00000, u};
      end
    end
  end

  // a held high surrogate alone produces no job
  assign push = accept && (push_job.has_cp || push_job.lead_fffd);

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_units     <= 1'b0;
      high_is_held   <= 1'b0;
      held_high_bits <= '0;
    end else if (cfg_valid && cfg_ready) begin
      wide_units     <= cfg_data;
      high_is_held   <= 1'b0;
      held_high_bits <= '0;
    end else if (accept) begin
      high_is_held   <= high_is_held_next;
      held_high_bits <= held_high_bits_next;
    end
  end

endmodule

// ----- rtl/u2u8_queue.sv -----
// small fifo of jobs between the front end and the byte emitter
module u2u8_queue
  import u2u8_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  u2u8_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output u2u8_job_t head_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  u2u8_job_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == DEPTH_CNT);
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/u2u8_back.sv -----
// back end: walks one job per pass and sends one utf-8 byte per cycle while a job waits and the output is not stalled
module u2u8_back
  import u2u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  u2u8_job_t  head_job,
  output logic       pop,
  output logic       byte_valid,
  input  logic       byte_stall,
  output byte_word_t byte_word
);

  logic [2:0] step;
  logic [2:0] cp_len;
  logic [2:0] lead_n;
  logic [2:0] total;
  logic [2:0] k_full;
  logic       in_fffd;
  logic       last;
  logic       load;
  logic [7:0] next_byte;

  assign cp_len  = utf8_len(head_job.cp);
  assign lead_n  = head_job.lead_fffd ? REPLACE_LEN : 3'd0;
  assign total   = lead_n + (head_job.has_cp ? cp_len : 3'd0);
  assign in_fffd = head_job.lead_fffd && (step < REPLACE_LEN);
  assign k_full  = step - lead_n;
  assign last    = (step == total - 3'd1);

  always_comb begin
    if (in_fffd) begin
      next_byte = utf8_byte_at(REPLACE_CP, REPLACE_LEN, step[1:0]);
    end else begin
      next_byte = utf8_byte_at(head_job.cp, cp_len, k_full[1:0]);
    end
  end

  // output register frees up when its word is taken
  assign load = head_valid && (!byte_valid || !byte_stall);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_word.utf8_byte <= next_byte;
      byte_word.run_end   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      step       <= '0;
    end else begin
      if (load) begin
        byte_valid <= 1'b1;
        step       <= last ? 3'd0 : step + 3'd1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/utf16_to_utf8_transcoder_core.sv -----
// utf-16/utf-32 to utf-8 transcoder top level
// the first byte of a word passes through the job queue, then the output byte register
// throughput: one byte per cycle while the output is not stalled; a word yields 0 to 6 bytes
// a word is accepted every cycle while the job queue has room, set by the byte emitter
// reset: queue empty, no surrogate held, 16-bit unit mode
module utf16_to_utf8_transcoder_core
  import u2u8_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       unit_valid,
  output logic       unit_stall,
  input  unit_word_t unit_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  output logic       byte_valid,
  input  logic       byte_stall,
  output byte_word_t byte_word
);

  logic      push;
  u2u8_job_t push_job;
  logic      queue_full;
  logic      pop;
  logic      head_valid;
  u2u8_job_t head_job;

  u2u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_word  (unit_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  u2u8_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  u2u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word)
  );

endmodule
